>>> rtl/ufmc_pkg.sv
`default_nettype none

package ufmc_pkg;

  // input field widths
  localparam int ROW_W = 5;
  localparam int COL_W = 5;
  // wall map coordinate width
  localparam int MAP_W = 6;

  // operation codes
  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_EDGE  = 1'b1;

  // edge direction codes
  localparam logic DIR_RIGHT = 1'b0;
  localparam logic DIR_DOWN  = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND,
    S_COMP,
    S_LINK,
    S_DONE
  } state_t;

  // which endpoint of the edge is being resolved
  typedef enum logic {
    PH_NEIGH,
    PH_CELL
  } phase_t;

  // one result word
  typedef struct packed {
    logic             wall_opened;
    logic [MAP_W-1:0] wall_map_row;
    logic [MAP_W-1:0] wall_map_col;
    logic             bad_edge;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/ufmc_parent_ram.sv
`default_nettype none

module ufmc_parent_ram #(
  parameter int DEPTH = 696,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] raddr,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [AW-1:0] wdata,
  output logic      [AW-1:0] rdata
);

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read with forwarding of a same-cycle write to the same entry
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/ufmc_ctrl.sv
`default_nettype none

module ufmc_ctrl #(
  parameter int GRID_ROWS = 29,
  parameter int GRID_COLS = 24,
  parameter int CELLS     = 696,
  parameter int AW        = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input word
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_operation,
  input  wire logic [ufmc_pkg::ROW_W-1:0] in_cell_row,
  input  wire logic [ufmc_pkg::COL_W-1:0] in_cell_col,
  input  wire logic                       in_edge_dir,
  // result toward the output register
  output logic                            res_valid,
  output ufmc_pkg::res_t                  res,
  input  wire logic                       out_free,
  // parent table port
  output logic      [AW-1:0]              ram_raddr,
  output logic                            ram_we,
  output logic      [AW-1:0]              ram_waddr,
  output logic      [AW-1:0]              ram_wdata,
  input  wire logic [AW-1:0]              ram_rdata
);

  localparam logic [AW-1:0] LAST_IDX = AW'(CELLS - 1);

  ufmc_pkg::state_t state_r, state_nxt;
  ufmc_pkg::phase_t phase_r, phase_nxt;
  ufmc_pkg::res_t   res_r, res_nxt;

  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          clr_item_r, clr_item_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic [AW-1:0] root_r, root_nxt;
  logic [AW-1:0] rootv_r, rootv_nxt;
  logic [AW-1:0] uidx_r, uidx_nxt;
  logic [ufmc_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [ufmc_pkg::COL_W-1:0] col_r, col_nxt;
  logic          dir_r, dir_nxt;

  // neighbor coordinates, range check and table indexes
  logic [ufmc_pkg::ROW_W:0] nrow_w;
  logic [ufmc_pkg::COL_W:0] ncol_w;
  logic                     bad_w;
  logic [AW-1:0]            vidx_w;
  logic [AW-1:0]            uidx_w;

  always_comb begin
    nrow_w = {1'b0, in_cell_row} + ((in_edge_dir == ufmc_pkg::DIR_DOWN) ? 6'd1 : 6'd0);
    ncol_w = {1'b0, in_cell_col} + ((in_edge_dir == ufmc_pkg::DIR_RIGHT) ? 6'd1 : 6'd0);
    bad_w  = (7'(in_cell_row) >= 7'(GRID_ROWS)) || (7'(in_cell_col) >= 7'(GRID_COLS)) ||
             (7'(nrow_w) >= 7'(GRID_ROWS)) || (7'(ncol_w) >= 7'(GRID_COLS));
    vidx_w = AW'(nrow_w) * AW'(GRID_COLS) + AW'(ncol_w);
    uidx_w = AW'(in_cell_row) * AW'(GRID_COLS) + AW'(in_cell_col);
  end

  // state and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ufmc_pkg::S_CLEAR;
      clr_cnt_r  <= '0;
      clr_item_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      clr_item_r <= clr_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    res_r   <= res_nxt;
    cur_r   <= cur_nxt;
    start_r <= start_nxt;
    root_r  <= root_nxt;
    rootv_r <= rootv_nxt;
    uidx_r  <= uidx_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    dir_r   <= dir_nxt;
  end

  // sequencer: clear sweep, root walks, compression, link
  logic          phase_end;
  logic [AW-1:0] root_w;

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    res_nxt      = res_r;
    clr_cnt_nxt  = clr_cnt_r;
    clr_item_nxt = clr_item_r;
    cur_nxt      = cur_r;
    start_nxt    = start_r;
    root_nxt     = root_r;
    rootv_nxt    = rootv_r;
    uidx_nxt     = uidx_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    dir_nxt      = dir_r;
    ram_raddr    = cur_r;
    ram_we       = 1'b0;
    ram_waddr    = cur_r;
    ram_wdata    = root_r;
    in_stall     = 1'b1;
    res_valid    = 1'b0;
    phase_end    = 1'b0;
    root_w       = root_r;

    unique case (state_r)
      // write identity, one entry per cycle
      ufmc_pkg::S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_IDX) begin
          clr_cnt_nxt  = '0;
          clr_item_nxt = 1'b0;
          res_nxt      = '0;
          state_nxt    = clr_item_r ? ufmc_pkg::S_DONE : ufmc_pkg::S_IDLE;
        end
      end
      ufmc_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          row_nxt = in_cell_row;
          col_nxt = in_cell_col;
          dir_nxt = in_edge_dir;
          priority if (in_operation == ufmc_pkg::OP_CLEAR) begin
            clr_item_nxt = 1'b1;
            clr_cnt_nxt  = '0;
            state_nxt    = ufmc_pkg::S_CLEAR;
          end else if (bad_w) begin
            res_nxt          = '0;
            res_nxt.bad_edge = 1'b1;
            state_nxt        = ufmc_pkg::S_DONE;
          end else begin
            cur_nxt   = vidx_w;
            start_nxt = vidx_w;
            uidx_nxt  = uidx_w;
            phase_nxt = ufmc_pkg::PH_NEIGH;
            ram_raddr = vidx_w;
            state_nxt = ufmc_pkg::S_FIND;
          end
        end
      end
      // one parent hop per cycle until an entry points at itself
      ufmc_pkg::S_FIND: begin
        if (ram_rdata == cur_r) begin
          if (start_r == cur_r) begin
            phase_end = 1'b1;
            root_w    = cur_r;
          end else begin
            root_nxt  = cur_r;
            cur_nxt   = start_r;
            ram_raddr = start_r;
            state_nxt = ufmc_pkg::S_COMP;
          end
        end else begin
          cur_nxt   = ram_rdata;
          ram_raddr = ram_rdata;
        end
      end
      // rewalk the path, pointing each entry at the root
      ufmc_pkg::S_COMP: begin
        ram_we    = 1'b1;
        ram_waddr = cur_r;
        ram_wdata = root_r;
        if (ram_rdata == root_r) begin
          phase_end = 1'b1;
          root_w    = root_r;
        end else begin
          cur_nxt   = ram_rdata;
          ram_raddr = ram_rdata;
        end
      end
      // join the two sets when the roots differ
      ufmc_pkg::S_LINK: begin
        res_nxt = '0;
        if (rootv_r != root_r) begin
          ram_we               = 1'b1;
          ram_waddr            = rootv_r;
          ram_wdata            = root_r;
          res_nxt.wall_opened  = 1'b1;
          res_nxt.wall_map_row = {row_r, 1'b0} +
                                 ((dir_r == ufmc_pkg::DIR_DOWN) ? 6'd2 : 6'd1);
          res_nxt.wall_map_col = {col_r, 1'b0} +
                                 ((dir_r == ufmc_pkg::DIR_DOWN) ? 6'd1 : 6'd2);
        end
        state_nxt = ufmc_pkg::S_DONE;
      end
      ufmc_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (out_free) begin
          state_nxt = ufmc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ufmc_pkg::S_IDLE;
      end
    endcase

    // end of one root lookup: start the cell side or go link
    if (phase_end) begin
      if (phase_r == ufmc_pkg::PH_NEIGH) begin
        rootv_nxt = root_w;
        phase_nxt = ufmc_pkg::PH_CELL;
        cur_nxt   = uidx_r;
        start_nxt = uidx_r;
        ram_raddr = uidx_r;
        state_nxt = ufmc_pkg::S_FIND;
      end else begin
        root_nxt  = root_w;
        state_nxt = ufmc_pkg::S_LINK;
      end
    end
  end

  assign res = res_r;

  // sweep writes identity entries
  a_clear_identity: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ufmc_pkg::S_CLEAR |-> ram_we && (ram_wdata == ram_waddr))
    else $error("clear sweep wrote a non-identity entry");

  // a link write only joins distinct roots
  a_link_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ufmc_pkg::S_LINK) && ram_we |-> rootv_r != root_r)
    else $error("link written for equal roots");

  // a finished result leaves once the output register frees
  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ufmc_pkg::S_DONE) && out_free |=> state_r == ufmc_pkg::S_IDLE)
    else $error("result not released");

  // a clear word starts the sweep at entry zero
  a_clear_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation == ufmc_pkg::OP_CLEAR)
    |=> (state_r == ufmc_pkg::S_CLEAR) && (clr_cnt_r == '0) && clr_item_r)
    else $error("clear word did not start the sweep");

endmodule

`default_nettype wire

>>> rtl/union_find_maze_carver_unit.sv
// After an edge word is accepted, out_valid rises once the parent hops from the two cells to
// their roots have been walked (one hop per cycle through the registered parent table read
// port, once to find, once to compress). A clear word rewrites the table one entry per cycle;
// its result follows the sweep. One word is taken at a time, the next once the last result
// has moved into the output register; reset (rst_n, synchronous) runs a clearing pass over
// all GRID_ROWS*GRID_COLS entries.
`default_nettype none

module union_find_maze_carver_unit #(
  parameter int GRID_ROWS = 29,
  parameter int GRID_COLS = 24
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_operation,
  input  wire logic [ufmc_pkg::ROW_W-1:0] in_cell_row,
  input  wire logic [ufmc_pkg::COL_W-1:0] in_cell_col,
  input  wire logic                       in_edge_dir,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_wall_opened,
  output logic      [ufmc_pkg::MAP_W-1:0] out_wall_map_row,
  output logic      [ufmc_pkg::MAP_W-1:0] out_wall_map_col,
  output logic                            out_bad_edge
);

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(CELLS);

  logic           ram_we;
  logic [AW-1:0]  ram_raddr;
  logic [AW-1:0]  ram_waddr;
  logic [AW-1:0]  ram_wdata;
  logic [AW-1:0]  ram_rdata;
  logic           res_valid;
  ufmc_pkg::res_t res;
  logic           out_free;

  logic           out_valid_r;
  ufmc_pkg::res_t out_res_r;

  // parent table
  ufmc_parent_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .raddr (ram_raddr),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // sequencer
  ufmc_ctrl #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS),
    .CELLS     (CELLS),
    .AW        (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_cell_row  (in_cell_row),
    .in_cell_col  (in_cell_col),
    .in_edge_dir  (in_edge_dir),
    .res_valid    (res_valid),
    .res          (res),
    .out_free     (out_free),
    .ram_raddr    (ram_raddr),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_rdata    (ram_rdata)
  );

  // output register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_wall_opened  = out_res_r.wall_opened;
  assign out_wall_map_row = out_res_r.wall_map_row;
  assign out_wall_map_col = out_res_r.wall_map_col;
  assign out_bad_edge     = out_res_r.bad_edge;

endmodule

`default_nettype wire
